// File: design/jse_pkg.sv
// package for the json string escaper: entry type, character codes, helpers
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W       = 3;

   localparam logic [7:0] CTRL_LIMIT  = 8'h1F;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] LETTER_B    = 8'h62;
   localparam logic [7:0] LETTER_F    = 8'h66;
   localparam logic [7:0] LETTER_N    = 8'h6E;
   localparam logic [7:0] LETTER_R    = 8'h72;
   localparam logic [7:0] LETTER_T    = 8'h74;
   localparam logic [7:0] LETTER_U    = 8'h75;
   localparam logic [7:0] DIGIT_ZERO  = 8'h30;
   localparam logic [7:0] HEX_ALPHA   = 8'h57;

   localparam logic [POS_W-1:0] POS_LAST_SHORT   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST_UNICODE = POS_W'(5);

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_SHORT,
      KIND_UNICODE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] code;
      logic       str_end;
   } entry_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         return DIGIT_ZERO + wide;
      end
      return HEX_ALPHA + wide;
   endfunction

endpackage
`default_nettype wire

// File: design/jse_front.sv
// front part: accepts input items and classifies each byte's escape form
`timescale 1ns / 1ps
`default_nettype none
module jse_front
   import jse_pkg::*;
(
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       req_tlast,
   input  wire logic       queue_full,
   output logic            push,
   output entry_type       push_entry
);

   always_comb begin
      push_entry.str_end = req_tlast;
      push_entry.kind    = KIND_SHORT;
      push_entry.code    = req_tdata;
      case (req_tdata)
         CHAR_QUOTE:  push_entry.code = CHAR_QUOTE;
         CHAR_BSLASH: push_entry.code = CHAR_BSLASH;
         CHAR_BS:     push_entry.code = LETTER_B;
         CHAR_FF:     push_entry.code = LETTER_F;
         CHAR_LF:     push_entry.code = LETTER_N;
         CHAR_CR:     push_entry.code = LETTER_R;
         CHAR_TAB:    push_entry.code = LETTER_T;
         default: begin
            if (req_tdata <= CTRL_LIMIT) begin
               push_entry.kind = KIND_UNICODE;
            end else begin
               push_entry.kind = KIND_PLAIN;
            end
         end
      endcase
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule
`default_nettype wire

// File: design/jse_queue.sv
// short queue of classified items between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module jse_queue
   import jse_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           empty,
   output entry_type      head
);

   entry_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_pop;

   assign full   = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = entries_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// File: design/jse_back.sv
// back part: serializes each queued item into its escaped bytes
`timescale 1ns / 1ps
`default_nettype none
module jse_back
   import jse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       queue_empty,
   input  wire entry_type  head,
   output logic            pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast,
   output logic            rsp_tuser
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   logic [7:0]       data_ff, data_in;
   logic             last_ff, last_in;
   logic             eos_ff, eos_in;
   logic             load;
   logic             take;

   // byte at the current position of the head item
   always_comb begin
      data_in = head.code;
      last_in = 1'b1;
      case (head.kind)
         KIND_PLAIN: begin
            data_in = head.code;
            last_in = 1'b1;
         end
         KIND_SHORT: begin
            data_in = (pos_ff == '0) ? CHAR_BSLASH : head.code;
            last_in = (pos_ff == POS_LAST_SHORT);
         end
         KIND_UNICODE: begin
            last_in = (pos_ff == POS_LAST_UNICODE);
            case (pos_ff)
               POS_W'(0): data_in = CHAR_BSLASH;
               POS_W'(1): data_in = LETTER_U;
               POS_W'(2): data_in = DIGIT_ZERO;
               POS_W'(3): data_in = DIGIT_ZERO;
               POS_W'(4): data_in = hex_digit(head.code[7:4]);
               default:   data_in = hex_digit(head.code[3:0]);
            endcase
         end
         default: begin
            data_in = head.code;
            last_in = 1'b1;
         end
      endcase
      eos_in = last_in && head.str_end;
   end

   assign load = !valid_ff || rsp_tready;
   assign take = load && !queue_empty;
   assign pop  = take && last_in;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = !queue_empty;
      end
      if (take) begin
         pos_in = last_in ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
         last_ff <= last_in;
         eos_ff  <= eos_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = eos_ff;

endmodule
`default_nettype wire

// File: design/json_string_escaper_top.sv
// top level of the json string escaper
//
// each req item carries one string byte (req_tdata) and the string-end flag
// (req_tlast). each input byte produces one to six rsp bytes: quote and
// backslash get a backslash prefix, backspace/form feed/newline/return/tab
// become two-byte letter escapes, other bytes up to 0x1f become \u00 plus two
// lower-case hex digits, everything else passes unchanged.
// rsp_tlast marks the final byte of each input byte's escape and rsp_tuser
// carries the string-end flag on that byte.
// an accepted item is first written into the queue and then loaded into the
// output register. while rsp_tready stays high, one rsp byte leaves per cycle,
// so plain bytes flow at one item per cycle; the back part serializes each
// escaped byte into two or six rsp bytes. a two-entry queue sits between the
// classifier and the serializer, and req_tready drops only when it is full.
// reset empties the queue and the output register. when the receiver stalls
// the output byte holds, the queue fills, and then req_tready goes low.
`timescale 1ns / 1ps
`default_nettype none
module json_string_escaper_top
   import jse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // in_byte[7:0]
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte[7:0]
   output logic            rsp_tlast,
   output logic            rsp_tuser    // end_of_string[0]
);

   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   jse_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   jse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   jse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

// File: design/jse_checker.sv
// port-level checks for the json string escaper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module jse_port_checks
   import jse_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_eos_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("string end flag on a non-final byte");

   // the high hex digit of a unicode escape is zero or one
   a_inner_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tdata == CHAR_BSLASH || rsp_tdata == LETTER_U || rsp_tdata == DIGIT_ZERO
         || rsp_tdata == hex_digit(4'h1))
      else $error("unexpected byte inside an escape");

   a_no_raw_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata > CTRL_LIMIT)
      else $error("control byte passed through unescaped");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind json_string_escaper_top jse_port_checks u_checker (.*);
`default_nettype wire

// File: sim/jse_checker.sv
// checker for the json string escaper: predicts each item's escape and compares rsp bytes
`timescale 1ns / 1ps
`default_nettype none
module jse_checker
   import jse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // in_byte[7:0]
   input  wire logic       req_tlast,
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // out_byte[7:0]
   input  wire logic       rsp_tlast,
   input  wire logic       rsp_tuser,   // end_of_string[0]
   output int              error_count,
   output int              pending
);

   localparam logic [7:0] LOWER_A = 8'h61;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       end_of_string;
   } escaped_byte_type;

   escaped_byte_type escaped_q[$];

   function automatic logic [7:0] nibble_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return DIGIT_ZERO + {4'h0, nib};
      end
      return LOWER_A + {4'h0, nib} - 8'd10;
   endfunction

   // expected escape bytes of one string byte
   task automatic queue_escape(input logic [7:0] raw, input logic str_end);
      logic [7:0]       seq [6];
      logic [7:0]       letter;
      int               len;
      escaped_byte_type entry;
      case (raw)
         CHAR_QUOTE:  letter = CHAR_QUOTE;
         CHAR_BSLASH: letter = CHAR_BSLASH;
         CHAR_BS:     letter = LETTER_B;
         CHAR_FF:     letter = LETTER_F;
         CHAR_LF:     letter = LETTER_N;
         CHAR_CR:     letter = LETTER_R;
         CHAR_TAB:    letter = LETTER_T;
         default:     letter = 8'h00;
      endcase
      if (letter != 8'h00) begin
         seq[0] = CHAR_BSLASH;
         seq[1] = letter;
         len = 2;
      end else if (raw <= CTRL_LIMIT) begin
         seq[0] = CHAR_BSLASH;
         seq[1] = LETTER_U;
         seq[2] = DIGIT_ZERO;
         seq[3] = DIGIT_ZERO;
         seq[4] = nibble_char(raw[7:4]);
         seq[5] = nibble_char(raw[3:0]);
         len = 6;
      end else begin
         seq[0] = raw;
         len = 1;
      end
      for (int k = 0; k < len; k++) begin
         entry.out_byte      = seq[k];
         entry.run_last      = (k == len - 1);
         entry.end_of_string = (k == len - 1) ? str_end : 1'b0;
         escaped_q.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      escaped_byte_type want;
      if (reset) begin
         error_count = 0;
         escaped_q.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (escaped_q.size() == 0) begin
               $error("unexpected rsp item: out_byte %h run_last %b end_of_string %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               error_count++;
            end else begin
               want = escaped_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.run_last) begin
                  $error("run_last: expected %b, actual %b", want.run_last, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== want.end_of_string) begin
                  $error("end_of_string: expected %b, actual %b",
                         want.end_of_string, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            queue_escape(req_tdata, req_tlast);
         end
         pending <= escaped_q.size();
      end
   end

endmodule
`default_nettype wire

// File: sim/tb.sv
// testbench top for the json string escaper: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import jse_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // in_byte[7:0]
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // out_byte[7:0]
   logic       rsp_tlast;
   logic       rsp_tuser;   // end_of_string[0]

   int error_count;
   int pending;
   int send_idle;
   int recv_idle;
   int sent;

   json_string_escaper_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   jse_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_byte(input logic [7:0] raw, input logic str_end);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tlast  <= str_end;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent++;
   endtask

   function automatic logic [7:0] string_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         return 8'($urandom_range(8'h20, 8'h7e));
      end else if (pick < 62) begin
         return 8'($urandom_range(8'h00, CTRL_LIMIT));
      end else if (pick < 72) begin
         return $urandom_range(1) ? CHAR_QUOTE : CHAR_BSLASH;
      end else if (pick < 92) begin
         return 8'($urandom_range(8'h80, 8'hff));
      end
      return 8'($urandom);
   endfunction

   // mostly whole strings, some bytes with a random end mark
   task automatic random_strings(input int target);
      int len;
      target += sent;
      while (sent < target) begin
         if ($urandom_range(9) == 0) begin
            send_byte(8'($urandom), 1'($urandom));
         end else begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
               send_byte(string_char(), k == len - 1);
            end
         end
      end
   endtask

   initial begin
      logic [7:0] directed [];
      directed = '{
         8'h41, 8'h00, 8'h1f, 8'h20, 8'hff, 8'h7f, 8'h80, CHAR_QUOTE, CHAR_BSLASH,
         CHAR_BS, CHAR_FF, CHAR_LF, CHAR_CR, CHAR_TAB, 8'h01, 8'h1a, 8'h0b, 8'h10,
         8'hc3, 8'ha9, 8'h62
      };
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      send_idle  = 12;
      recv_idle  = 87;
      sent       = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end mark on a lone byte, then the corner bytes
      send_byte(8'h5a, 1'b1);
      foreach (directed[i]) begin
         send_byte(directed[i], i == directed.size() - 1);
      end
      send_byte(CHAR_LF, 1'b1);

      // hold off until every escape has drained
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end

      random_strings(96);
      send_idle = 87;
      recv_idle = 12;
      random_strings(96);
      send_idle = 0;
      recv_idle = 0;
      random_strings(96);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (error_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
design/jse_pkg.sv
design/jse_front.sv
design/jse_queue.sv
design/jse_back.sv
design/json_string_escaper_top.sv
design/jse_checker.sv
sim/jse_checker.sv
sim/tb.sv
